>>> hdl/sitoa_pkg.sv
`timescale 1ns / 1ps

package sitoa_pkg;

    localparam int BIN_W      = 32;
    localparam int DIGITS     = 10;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int STEPS_PER  = 4;
    localparam int STAGES     = BIN_W / STEPS_PER;
    localparam int IDX_W      = $clog2(DIGITS);

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    typedef struct packed {
        logic               vld;
        logic               neg;
        logic [BCD_W-1:0]   bcd;
        logic [BIN_W-1:0]   bin;
    } t_work;

    // one shift-and-add-three step over the whole bcd/binary word
    function automatic t_work dd_step(input t_work w);
        t_work            r;
        logic [BCD_W-1:0] adj;
        logic [3:0]       d;
        r   = w;
        adj = w.bcd;
        for (int k = 0; k < DIGITS; k++) begin
            d = w.bcd[4*k +: 4];
            if (d >= 4'd5) begin
                adj[4*k +: 4] = d + 4'd3;
            end
        end
        r.bcd = {adj[BCD_W-2:0], w.bin[BIN_W-1]};
        r.bin = {w.bin[BIN_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

>>> hdl/sitoa_dd_stage.sv
`timescale 1ns / 1ps

module sitoa_dd_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  sitoa_pkg::t_work i_work,
    output sitoa_pkg::t_work o_work
);
    import sitoa_pkg::*;

    t_work r_work;
    t_work n_work;

    always_comb begin
        n_work = i_work;
        for (int s = 0; s < STEPS_PER; s++) begin
            n_work = dd_step(n_work);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work.vld <= 1'b0;
        end else if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_work = r_work;

endmodule

>>> hdl/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps

// signed 32-bit integer to decimal ascii text
// input: a transfer happens on a rising edge with i_start high and o_busy low;
//   i_value is the two's complement integer to convert
// output: one character per cycle on o_character, marked by o_valid; the
//   final character of a number has o_last_char set; a negative number
//   starts with '-', zero gives a single '0', no leading zeros
// the receiver cannot stall: each character is present for one cycle only
// path: with the serialiser free, the input passes in turn through
//   one magnitude stage, eight binary-to-bcd stages of four steps each,
//   the load into the character serialiser and the output register
// throughput: one input enters the pipeline per cycle while it has room;
//   sustained, the rate is set by the serialiser, which sends one character
//   per cycle, and an item has 1 to 11 characters; o_busy rises and the
//   whole pipeline holds while an item at its end waits for the serialiser
// reset: clears all valid bits and the serialiser's state flags; data registers are not reset
module signed_int_to_decimal_ascii_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [sitoa_pkg::BIN_W-1:0] i_value,
    output logic                           o_busy,
    output logic                           o_valid,
    output logic [7:0]                     o_character,
    output logic                           o_last_char
);
    import sitoa_pkg::*;

    t_work             r_front;
    t_work             n_front;
    t_work             stage_w [0:STAGES];
    logic              adv;
    logic              ser_load;
    logic              ser_free;
    t_work             tail;

    logic              r_act;
    logic              r_neg_pend;
    logic [BCD_W-1:0]  r_digits;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  msd;

    logic              r_o_valid;
    logic [7:0]        r_o_char;
    logic              r_o_last;
    logic              n_o_valid;
    logic [7:0]        n_o_char;
    logic              n_o_last;
    logic [3:0]        cur_digit;

    assign tail     = stage_w[STAGES];
    assign ser_free = !r_act || (!r_neg_pend && (r_idx == '0));
    assign ser_load = tail.vld && ser_free;
    assign adv      = !tail.vld || ser_load;
    assign o_busy   = !adv;

    // magnitude stage
    always_comb begin
        n_front.vld = i_start;
        n_front.neg = i_value[BIN_W-1];
        n_front.bcd = '0;
        n_front.bin = i_value[BIN_W-1] ? (~i_value + 1'b1) : i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.vld <= 1'b0;
        end else if (adv) begin
            r_front <= n_front;
        end
    end

    assign stage_w[0] = r_front;

    for (genvar g = 0; g < STAGES; g++) begin : g_dd
        sitoa_dd_stage u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_work (stage_w[g]),
            .o_work (stage_w[g+1])
        );
    end

    // most significant non-zero digit
    always_comb begin
        msd = '0;
        for (int k = 0; k < DIGITS; k++) begin
            if (tail.bcd[4*k +: 4] != 4'd0) begin
                msd = IDX_W'(k);
            end
        end
    end

    assign cur_digit = r_digits[{r_idx, 2'b00} +: 4];

    always_comb begin
        n_o_valid = r_act;
        n_o_char  = ASCII_MINUS;
        n_o_last  = 1'b0;
        if (!r_neg_pend) begin
            n_o_char = ASCII_ZERO + {4'd0, cur_digit};
            n_o_last = (r_idx == '0);
        end
    end

    // character serialiser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act      <= 1'b0;
            r_neg_pend <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
            if (ser_load) begin
                r_act      <= 1'b1;
                r_neg_pend <= tail.neg;
            end else if (r_act) begin
                if (r_neg_pend) begin
                    r_neg_pend <= 1'b0;
                end else if (r_idx == '0) begin
                    r_act <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_char <= n_o_char;
        r_o_last <= n_o_last;
        if (ser_load) begin
            r_digits <= tail.bcd;
            r_idx    <= msd;
        end else if (r_act && !r_neg_pend && (r_idx != '0)) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_character = r_o_char;
    assign o_last_char = r_o_last;

endmodule
